/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files of the base64 stream encoder
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define B64SE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// property checked on every rising clock edge, reset included
`define B64SE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define B64SE_ASSERT(lbl, prop)
`define B64SE_ASSERT_RST(lbl, prop)
`endif

`endif

/* hw/rtl/b64se_pkg.sv */
// types, constants and the alphabet lookup of the base64 stream encoder
// no dependencies
package b64se_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned JOB_CHARS   = 4;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_LOWER = 8'h61;
  localparam logic [7:0] ASCII_DIGIT = 8'h30;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;

  // characters caused by one input word
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;    // character k at chars[k]
    logic [1:0]                last_idx; // index of the last valid character
    logic                      fin;      // last character ends the stream
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // sextet to base64 ascii character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return ASCII_UPPER + w;
    end else if (v < 6'd52) begin
      return ASCII_LOWER + w - 8'd26;
    end else if (v < 6'd62) begin
      return ASCII_DIGIT + w - 8'd52;
    end else if (v == 6'd62) begin
      return ASCII_PLUS;
    end else begin
      return ASCII_SLASH;
    end
  endfunction

  // true for a character of the alphabet or the pad
  function automatic logic is_out_char(input logic [7:0] c);
    return (c >= ASCII_UPPER && c < ASCII_UPPER + 8'd26) ||
           (c >= ASCII_LOWER && c < ASCII_LOWER + 8'd26) ||
           (c >= ASCII_DIGIT && c < ASCII_DIGIT + 8'd10) ||
           (c == ASCII_PLUS) || (c == ASCII_SLASH) || (c == PAD_CHAR);
  endfunction

endpackage

/* hw/rtl/b64se_front.sv */
// front end: takes input words, tracks the group position and leftover
// bits, and turns each word into a job of one to four characters; uses b64se_pkg
module b64se_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // data_byte[7:0]
  input  logic            in_tlast,   // final_byte
  input  b64se_pkg::queue_stat_t q_stat,
  output logic            push,
  output b64se_pkg::job_t push_job
);
  import b64se_pkg::*;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // build the job and the next group state
  always_comb begin
    push_job.chars    = '0;
    push_job.last_idx = 2'd0;
    push_job.fin      = in_tlast;
    pos_nxt           = pos_r;
    left_nxt          = left_r;
    unique case (pos_r)
      POS_SECOND: begin
        push_job.chars[0] = sextet_char({left_r[1:0], in_tdata[7:4]});
        if (in_tlast) begin
          push_job.chars[1] = sextet_char({in_tdata[3:0], 2'b00});
          push_job.chars[2] = PAD_CHAR;
          push_job.last_idx = 2'd2;
          pos_nxt           = POS_FIRST;
          left_nxt          = 4'd0;
        end else begin
          pos_nxt  = POS_THIRD;
          left_nxt = in_tdata[3:0];
        end
      end
      POS_THIRD: begin
        push_job.chars[0] = sextet_char({left_r, in_tdata[7:6]});
        push_job.chars[1] = sextet_char(in_tdata[5:0]);
        push_job.last_idx = 2'd1;
        pos_nxt           = POS_FIRST;
        left_nxt          = 4'd0;
      end
      default: begin
        // first position, and the unused code treated the same way
        push_job.chars[0] = sextet_char(in_tdata[7:2]);
        if (in_tlast) begin
          push_job.chars[1] = sextet_char({in_tdata[1:0], 4'b0000});
          push_job.chars[2] = PAD_CHAR;
          push_job.chars[3] = PAD_CHAR;
          push_job.last_idx = 2'd3;
          pos_nxt           = POS_FIRST;
          left_nxt          = 4'd0;
        end else begin
          pos_nxt  = POS_SECOND;
          left_nxt = {2'b00, in_tdata[1:0]};
        end
      end
    endcase
  end

  // group state advances on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_FIRST;
      left_r <= 4'd0;
    end else if (push) begin
      pos_r  <= pos_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

/* hw/rtl/b64se_fifo.sv */
// short job queue between the front and back ends
// uses b64se_pkg; depth must be a power of two, at least two
module b64se_fifo #(
  parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64se_pkg::job_t push_job,
  input  logic            pop,
  output b64se_pkg::job_t pop_job,
  output b64se_pkg::queue_stat_t q_stat
);
  import b64se_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job      = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/b64se_back.sv */
// back end: takes jobs from the queue and sends their characters one word
// a cycle, out_tready allowing, via the output register; uses b64se_pkg
module b64se_back (
  input  logic            clk,
  input  logic            rst_n,
  input  b64se_pkg::queue_stat_t q_stat,
  input  b64se_pkg::job_t pop_job,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // out_char[7:0]
  output logic            out_tlast   // final_char
);
  import b64se_pkg::*;

  job_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       valid_r;

  logic load;
  logic cur_done;

  // move a character whenever the output register is free or being taken
  assign load     = cur_valid_r && (!valid_r || out_tready);
  assign cur_done = load && (idx_r == cur_r.last_idx);
  assign pop      = (!cur_valid_r || cur_done) && !q_stat.empty;

  // current job and character index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (cur_done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_r.chars[idx_r];
      last_r <= cur_r.fin && (idx_r == cur_r.last_idx);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

endmodule

/* hw/rtl/base64_stream_encoder_core.sv */
// top level of the base64 stream encoder: front end, job queue, back end
// uses b64se_pkg, b64se_front, b64se_fifo, b64se_back and assert_macros.svh
//
//   channel  direction  tdata           tuser  tlast
//   in_      slave      data_byte[7:0]  -      final_byte
//   out_     master     out_char[7:0]   -      final_char
//
// a byte is taken whenever the job queue has room; its one to four
// characters leave one per cycle from the output register while
// out_tready is high and jobs are queued.
// the output register and the single-character back end set the rate.
// each character moves via queue entry, job register and output register.
// synchronous active-low reset clears group state, queue and output valid.
// a stalled output fills the queue, then in_tready drops; no word is lost.
`include "assert_macros.svh"

module base64_stream_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte[7:0]
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char[7:0]
  output logic       out_tlast   // final_char
);
  import b64se_pkg::*;

  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        pop_job;
  queue_stat_t q_stat;

  // classify and expand input words
  b64se_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  b64se_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // character sequencer and output register
  b64se_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // checks
  `B64SE_ASSERT(a_queue_stat_sane, !(q_stat.full && q_stat.empty))
  `B64SE_ASSERT(a_pop_not_empty, pop |-> !q_stat.empty)
  `B64SE_ASSERT(a_out_char_legal, out_tvalid |-> is_out_char(out_tdata))
  `B64SE_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_tvalid)

endmodule
